// ===== rtl/power_overload_and_change_monitor_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the power overload and change monitor
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POWER_OVERLOAD_AND_CHANGE_MONITOR_DEFINES_SVH
`define POWER_OVERLOAD_AND_CHANGE_MONITOR_DEFINES_SVH

// Same-cycle implication
`define POM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define POM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pom_pkg.sv =====
// ----------------------------------------------------------------------------
// pom_pkg
// Types and constants shared by the power overload and change monitor.
// ----------------------------------------------------------------------------
package pom_pkg;

	localparam int unsigned AddrW = 5;
	localparam int unsigned DataW = 32;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_POWER_LIMIT   = 3'd0;
	localparam logic [2:0] REG_HOLD_MS       = 3'd1;
	localparam logic [2:0] REG_POWER_THRESH  = 3'd2;
	localparam logic [2:0] REG_VOLT_THRESH   = 3'd3;
	localparam logic [2:0] REG_CURR_THRESH   = 3'd4;
	localparam logic [2:0] REG_IDLE_TIMEOUT  = 3'd5;

	// reset values
	localparam logic [17:0] RST_POWER_LIMIT  = 18'd800;
	localparam logic [31:0] RST_HOLD_MS      = 32'd10000;
	localparam logic [17:0] RST_POWER_THRESH = 18'd10;
	localparam logic [15:0] RST_VOLT_THRESH  = 16'd10;
	localparam logic [16:0] RST_CURR_THRESH  = 17'd100;
	localparam logic [31:0] RST_IDLE_TIMEOUT = 32'd90000;

	typedef struct packed {
		logic [17:0] power_limit;
		logic [31:0] hold_ms;
		logic [17:0] power_thresh;
		logic [15:0] volt_thresh;
		logic [16:0] curr_thresh;
		logic [31:0] idle_timeout;
	} cfg_t;

	typedef struct packed {
		logic relay_on;
		logic overload;
		logic publish;
		logic sleep_request;
	} result_t;

endpackage

// ===== rtl/power_overload_and_change_monitor.sv =====
// ----------------------------------------------------------------------------
// power_overload_and_change_monitor
// Meter sample monitor: overload relay control, change reporting, idle sleep.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle with no bubbles while results drain. An
// accepted item sits in an input register while the overload, change and
// idle decisions are evaluated and the internal state is updated; its
// result then moves to an output register and is offered on out_valid. The
// two registers hold at most two items: while a result waits for out_ready
// the input register fills and in_ready drops until that result is taken.
// Limits and thresholds are written over the APB port (register i at byte
// address 4*i) and should only change while no item is in flight.
module power_overload_and_change_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pom_pkg::AddrW-1:0]   paddr,
	input  logic [pom_pkg::DataW-1:0]   pwdata,
	output logic [pom_pkg::DataW-1:0]   prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        sample_valid,
	input  logic [15:0]                 voltage,
	input  logic [16:0]                 current,
	input  logic [17:0]                 power,
	input  logic [31:0]                 now_ms,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        relay_on,
	output logic                        overload,
	output logic                        publish,
	output logic                        sleep_request
);

	pom_pkg::cfg_t    cfg;
	pom_pkg::result_t res;
	pom_pkg::result_t res_s2;

	logic        vld_s1;
	logic        smp_vld_s1;
	logic [15:0] voltage_s1;
	logic [16:0] current_s1;
	logic [17:0] power_s1;
	logic [31:0] now_s1;
	logic        vld_s2;
	logic        adv;
	logic        take;

	pom_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the held item when the result register is free or draining
	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			smp_vld_s1 <= sample_valid;
			voltage_s1 <= voltage;
			current_s1 <= current;
			power_s1   <= power;
			now_s1     <= now_ms;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	pom_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step         (adv),
		.sample_valid (smp_vld_s1),
		.voltage      (voltage_s1),
		.current      (current_s1),
		.power        (power_s1),
		.now_ms       (now_s1),
		.res          (res)
	);

	assign out_valid     = vld_s2;
	assign relay_on      = res_s2.relay_on;
	assign overload      = res_s2.overload;
	assign publish       = res_s2.publish;
	assign sleep_request = res_s2.sleep_request;

endmodule

// ===== rtl/pom_cfg.sv =====
// ----------------------------------------------------------------------------
// pom_cfg
// APB register file holding the monitor's limits, thresholds and timeouts.
// ----------------------------------------------------------------------------
module pom_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pom_pkg::AddrW-1:0]   paddr,
	input  logic [pom_pkg::DataW-1:0]   pwdata,
	output logic [pom_pkg::DataW-1:0]   prdata,
	output logic                        pready,
	output pom_pkg::cfg_t               cfg
);

	pom_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_limit  <= pom_pkg::RST_POWER_LIMIT;
			cfg_q.hold_ms      <= pom_pkg::RST_HOLD_MS;
			cfg_q.power_thresh <= pom_pkg::RST_POWER_THRESH;
			cfg_q.volt_thresh  <= pom_pkg::RST_VOLT_THRESH;
			cfg_q.curr_thresh  <= pom_pkg::RST_CURR_THRESH;
			cfg_q.idle_timeout <= pom_pkg::RST_IDLE_TIMEOUT;
		end else if (wr_en) begin
			case (idx)
				pom_pkg::REG_POWER_LIMIT:  cfg_q.power_limit  <= pwdata[17:0];
				pom_pkg::REG_HOLD_MS:      cfg_q.hold_ms      <= pwdata;
				pom_pkg::REG_POWER_THRESH: cfg_q.power_thresh <= pwdata[17:0];
				pom_pkg::REG_VOLT_THRESH:  cfg_q.volt_thresh  <= pwdata[15:0];
				pom_pkg::REG_CURR_THRESH:  cfg_q.curr_thresh  <= pwdata[16:0];
				pom_pkg::REG_IDLE_TIMEOUT: cfg_q.idle_timeout <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			pom_pkg::REG_POWER_LIMIT:  prdata = {14'd0, cfg_q.power_limit};
			pom_pkg::REG_HOLD_MS:      prdata = cfg_q.hold_ms;
			pom_pkg::REG_POWER_THRESH: prdata = {14'd0, cfg_q.power_thresh};
			pom_pkg::REG_VOLT_THRESH:  prdata = {16'd0, cfg_q.volt_thresh};
			pom_pkg::REG_CURR_THRESH:  prdata = {15'd0, cfg_q.curr_thresh};
			pom_pkg::REG_IDLE_TIMEOUT: prdata = cfg_q.idle_timeout;
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== rtl/pom_core.sv =====
// ----------------------------------------------------------------------------
// pom_core
// Overload latch, report snapshot and idle check; evaluates one item per step.
// ----------------------------------------------------------------------------
`include "power_overload_and_change_monitor_defines.svh"

module pom_core (
	input  logic              clk,
	input  logic              arst_n,
	input  pom_pkg::cfg_t     cfg,
	input  logic              step,
	input  logic              sample_valid,
	input  logic [15:0]       voltage,
	input  logic [16:0]       current,
	input  logic [17:0]       power,
	input  logic [31:0]       now_ms,
	output pom_pkg::result_t  res
);

	logic        ovl_q;
	logic [31:0] ovl_start_q;
	logic        relay_q;
	logic [15:0] saved_v_q;
	logic [16:0] saved_c_q;
	logic [17:0] saved_p_q;
	logic        reported_q;
	logic [31:0] last_rpt_q;

	logic        over_limit;
	logic        hold_done;
	logic        start_ovl;
	logic        end_ovl;
	logic        ovl_nxt;
	logic        relay_nxt;
	logic [15:0] dv;
	logic [16:0] dc;
	logic [17:0] dp;
	logic [31:0] since_rpt;
	logic        pub;
	logic        slp;

	assign over_limit = power > cfg.power_limit;
	assign hold_done  = (now_ms - ovl_start_q) > cfg.hold_ms;
	assign start_ovl  = sample_valid && over_limit && !ovl_q;
	assign end_ovl    = sample_valid && !over_limit && ovl_q && hold_done;

	always_comb begin
		ovl_nxt   = ovl_q;
		relay_nxt = relay_q;
		if (start_ovl) begin
			ovl_nxt   = 1'b1;
			relay_nxt = 1'b0;
		end else if (sample_valid && !over_limit && (!ovl_q || hold_done)) begin
			ovl_nxt   = 1'b0;
			relay_nxt = 1'b1;
		end
	end

	assign dv = (voltage > saved_v_q) ? voltage - saved_v_q : saved_v_q - voltage;
	assign dc = (current > saved_c_q) ? current - saved_c_q : saved_c_q - current;
	assign dp = (power > saved_p_q) ? power - saved_p_q : saved_p_q - power;

	assign pub = sample_valid && ((dp > cfg.power_thresh) || (dc > cfg.curr_thresh) ||
		(dv > cfg.volt_thresh) || !reported_q);

	// a reporting item resets the idle time to zero
	assign since_rpt = now_ms - last_rpt_q;
	assign slp       = sample_valid && !pub && (since_rpt > cfg.idle_timeout);

	assign res.relay_on      = relay_nxt;
	assign res.overload      = ovl_nxt;
	assign res.publish       = pub;
	assign res.sleep_request = slp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_q       <= 1'b0;
			ovl_start_q <= '0;
			relay_q     <= 1'b1;
			saved_v_q   <= '0;
			saved_c_q   <= '0;
			saved_p_q   <= '0;
			reported_q  <= 1'b0;
			last_rpt_q  <= '0;
		end else if (step) begin
			ovl_q   <= ovl_nxt;
			relay_q <= relay_nxt;
			if (start_ovl) begin
				ovl_start_q <= now_ms;
			end
			if (pub) begin
				saved_v_q  <= voltage;
				saved_c_q  <= current;
				saved_p_q  <= power;
				reported_q <= 1'b1;
				last_rpt_q <= now_ms;
			end
		end
	end

	`POM_ASSERT_NOW(a_relay_vs_latch, 1'b1, relay_q != ovl_q, "relay closed while overload latched")
	`POM_ASSERT_NEXT(a_invalid_holds, step && !sample_valid, $stable(ovl_q) && $stable(saved_p_q) && $stable(last_rpt_q), "invalid item changed state")
	`POM_ASSERT_NEXT(a_publish_marks, step && pub, reported_q && (last_rpt_q == $past(now_ms)), "report not recorded")
	`POM_ASSERT_NOW(a_end_needs_hold, end_ovl, hold_done && !start_ovl, "overload released early")

endmodule
